FILE: rtl/jsesc_pkg.sv
package jsesc_pkg;

  localparam int RunMax = 15;
  localparam int RunIdxW = 4;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [RunMax-1:0][7:0] data;
    logic [RunIdxW-1:0]     cnt;
    logic                   done;
  } run_t;

  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5c;
  localparam byte_t CH_B      = 8'h62;
  localparam byte_t CH_F      = 8'h66;
  localparam byte_t CH_N      = 8'h6e;
  localparam byte_t CH_R      = 8'h72;
  localparam byte_t CH_T      = 8'h74;
  localparam byte_t CH_U      = 8'h75;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_LC_A   = 8'h61;

  localparam byte_t CC_BS  = 8'h08;
  localparam byte_t CC_TAB = 8'h09;
  localparam byte_t CC_LF  = 8'h0a;
  localparam byte_t CC_FF  = 8'h0c;
  localparam byte_t CC_CR  = 8'h0d;
  localparam byte_t CC_NUL = 8'h00;
  localparam byte_t CC_SP  = 8'h20;

  localparam byte_t REP_0 = 8'hef;
  localparam byte_t REP_1 = 8'hbf;
  localparam byte_t REP_2 = 8'hbd;

  localparam byte_t LEAD_MIN = 8'hc2;
  localparam byte_t LEAD2_MAX = 8'hdf;
  localparam byte_t LEAD3_MAX = 8'hef;
  localparam byte_t LEAD_MAX = 8'hf4;
  localparam byte_t LEAD_E0 = 8'he0;
  localparam byte_t LEAD_ED = 8'hed;
  localparam byte_t LEAD_F0 = 8'hf0;
  localparam byte_t LEAD_F4 = 8'hf4;
  localparam byte_t E0_MIN = 8'ha0;
  localparam byte_t ED_MAX = 8'h9f;
  localparam byte_t F0_MIN = 8'h90;
  localparam byte_t F4_MAX = 8'h8f;

endpackage

FILE: rtl/jsesc_decode.sv
module jsesc_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  jsesc_pkg::byte_t  byte_i,
  output jsesc_pkg::run_t   run
);
  import jsesc_pkg::*;

  function automatic byte_t hex_lower(input logic [3:0] v);
    byte_t r;
    if (v < 4'd10) r = CH_ZERO + {4'd0, v};
    else r = CH_LC_A + {4'd0, v - 4'd10};
    return r;
  endfunction

  logic           inside_r, inside_nxt;
  byte_t          held_r [3];
  logic [1:0]     hc_r, hc_nxt;
  logic [2:0]     sl_r, sl_nxt;

  logic [1:0]     eff_hc;
  logic           cont, cont_ok, complete, fail, fresh_en, is_lead;
  byte_t          pre [RunMax];
  byte_t          fr [8];
  logic [2:0]     fcnt;
  logic [3:0]     pre_cnt, j;

  always_comb begin
    eff_hc = inside_r ? hc_r : 2'd0;
    cont = (byte_i[7:6] == 2'b10);
    if (hc_r == 2'd1) begin
      if ((held_r[0] == LEAD_E0 && byte_i < E0_MIN) ||
          (held_r[0] == LEAD_ED && byte_i > ED_MAX) ||
          (held_r[0] == LEAD_F0 && byte_i < F0_MIN) ||
          (held_r[0] == LEAD_F4 && byte_i > F4_MAX)) begin
        cont = 1'b0;
      end
    end
    cont_ok  = (eff_hc != 2'd0) && cont;
    complete = cont_ok && (({1'b0, hc_r} + 3'd1) >= sl_r);
    fail     = (eff_hc != 2'd0) && !cont;
    fresh_en = !cont_ok;
    is_lead  = (byte_i >= LEAD_MIN) && (byte_i <= LEAD_MAX);
  end

  // prefix: opening quote, completed sequence, or replacement for held bytes
  always_comb begin
    for (int k = 0; k < RunMax; k++) begin
      pre[k] = '0;
    end
    pre_cnt = '0;
    if (!inside_r) begin
      pre[0]  = CH_QUOTE;
      pre_cnt = 4'd1;
    end else if (complete) begin
      for (int k = 0; k < 4; k++) begin
        if (k < 3 && 2'(k) < hc_r) pre[k] = held_r[k];
        else if (2'(k) == hc_r) pre[k] = byte_i;
      end
      pre_cnt = {2'b0, hc_r} + 4'd1;
    end else if (fail) begin
      for (int k = 0; k < 9; k++) begin
        case (k % 3)
          0:       pre[k] = REP_0;
          1:       pre[k] = REP_1;
          default: pre[k] = REP_2;
        endcase
      end
      pre_cnt = {2'b0, hc_r} * 4'd3;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      fr[k] = '0;
    end
    fcnt = 3'd0;
    case (byte_i)
      CC_NUL:    begin fr[0] = CH_QUOTE;  fcnt = 3'd1; end
      CH_QUOTE:  begin fr[0] = CH_BSLASH; fr[1] = CH_QUOTE;  fcnt = 3'd2; end
      CH_BSLASH: begin fr[0] = CH_BSLASH; fr[1] = CH_BSLASH; fcnt = 3'd2; end
      CC_BS:     begin fr[0] = CH_BSLASH; fr[1] = CH_B;      fcnt = 3'd2; end
      CC_FF:     begin fr[0] = CH_BSLASH; fr[1] = CH_F;      fcnt = 3'd2; end
      CC_LF:     begin fr[0] = CH_BSLASH; fr[1] = CH_N;      fcnt = 3'd2; end
      CC_CR:     begin fr[0] = CH_BSLASH; fr[1] = CH_R;      fcnt = 3'd2; end
      CC_TAB:    begin fr[0] = CH_BSLASH; fr[1] = CH_T;      fcnt = 3'd2; end
      default: begin
        if (byte_i < CC_SP) begin
          fr[0] = CH_BSLASH;
          fr[1] = CH_U;
          fr[2] = CH_ZERO;
          fr[3] = CH_ZERO;
          fr[4] = hex_lower(byte_i[7:4]);
          fr[5] = hex_lower(byte_i[3:0]);
          fcnt  = 3'd6;
        end else if (!byte_i[7]) begin
          fr[0] = byte_i;
          fcnt  = 3'd1;
        end else if (!is_lead) begin
          fr[0] = REP_0;
          fr[1] = REP_1;
          fr[2] = REP_2;
          fcnt  = 3'd3;
        end
      end
    endcase
    if (!fresh_en) fcnt = 3'd0;
  end

  always_comb begin
    run.cnt  = pre_cnt + {1'b0, fcnt};
    run.done = fresh_en && (byte_i == CC_NUL);
    j = '0;
    for (int k = 0; k < RunMax; k++) begin
      run.data[k] = '0;
      j = 4'(k) - pre_cnt;
      if (4'(k) < pre_cnt) run.data[k] = pre[k];
      else if (j < 4'd6) run.data[k] = fr[j[2:0]];
    end
  end

  always_comb begin
    inside_nxt = !(fresh_en && byte_i == CC_NUL);
    hc_nxt = 2'd0;
    sl_nxt = 3'd0;
    if (cont_ok && !complete) begin
      hc_nxt = hc_r + 2'd1;
      sl_nxt = sl_r;
    end else if (fresh_en && is_lead) begin
      hc_nxt = 2'd1;
      sl_nxt = (byte_i <= LEAD2_MAX) ? 3'd2 : ((byte_i <= LEAD3_MAX) ? 3'd3 : 3'd4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      hc_r     <= 2'd0;
      sl_r     <= 3'd0;
    end else if (take) begin
      inside_r <= inside_nxt;
      hc_r     <= hc_nxt;
      sl_r     <= sl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (cont_ok && !complete) held_r[hc_r] <= byte_i;
      else if (fresh_en && is_lead) held_r[0] <= byte_i;
    end
  end

endmodule

FILE: rtl/jsesc_emit.sv
module jsesc_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              run_valid,
  input  jsesc_pkg::run_t   run,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output jsesc_pkg::byte_t  out_byte,
  output logic              out_last_of_run,
  output logic              out_string_done
);
  import jsesc_pkg::*;

  logic [RunMax-1:0][7:0] data_r;
  logic [RunIdxW-1:0]     cnt_r, idx_r;
  logic                   done_r, v_r;
  logic                   last, xfer, ready;

  assign last  = (idx_r == cnt_r - 1'b1);
  assign xfer  = v_r && !out_stall;
  assign ready = !v_r || (xfer && last);
  assign take  = run_valid && ready;

  assign out_valid       = v_r;
  assign out_byte        = data_r[idx_r];
  assign out_last_of_run = last;
  assign out_string_done = done_r && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= '0;
    end else if (take && run.cnt != '0) begin
      v_r   <= 1'b1;
      idx_r <= '0;
    end else if (xfer && last) begin
      v_r   <= 1'b0;
    end else if (xfer) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= run.data;
      cnt_r  <= run.cnt;
      done_r <= run.done;
    end
  end

endmodule

FILE: rtl/json_string_escape_utf8_check_unit.sv
// An input byte passes the input register and the emitter's run register
// before its first output byte. Throughput: one input byte per cycle while
// out_stall is low and each byte yields at most one output byte; the rate is
// set by the emitter's single run register, held until its last byte goes.
// Reset (synchronous, rst_n low) closes any open string and drops held bytes.
module json_string_escape_utf8_check_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jsesc_pkg::byte_t  in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output jsesc_pkg::byte_t  out_byte,
  output logic              out_last_of_run,
  output logic              out_string_done
);
  import jsesc_pkg::*;

  logic   in_v_r;
  byte_t  in_byte_r;
  logic   take;
  run_t   run;

  assign in_stall = in_v_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  jsesc_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .byte_i (in_byte_r),
    .run    (run)
  );

  jsesc_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .run_valid       (in_v_r),
    .run             (run),
    .take            (take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_done |-> out_last_of_run)
    else $error("closing quote not last of run");

  a_done_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_done |-> out_byte == CH_QUOTE)
    else $error("closing byte is not a quote");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("run ended early");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with output idle");

endmodule

FILE: bench/quote_checker.sv
module quote_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  jsesc_pkg::byte_t  in_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  jsesc_pkg::byte_t  out_byte,
  input  logic              out_last_of_run,
  input  logic              out_string_done,
  output int                fail_count,
  output int                pending
);
  import jsesc_pkg::*;

  localparam byte_t AsciiEnd = 8'h80;
  localparam int PrintCap = 100;

  typedef struct packed {
    byte_t value;
    logic  last;
    logic  done;
  } quoted_t;

  quoted_t quoted_q[$];
  quoted_t run_buf[$];
  int      mismatches = 0;

  // predictor state
  logic       in_str;
  byte_t      held [3];
  logic [1:0] held_cnt;
  logic [2:0] seq_len;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    if (mismatches < PrintCap) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic byte_t hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + byte_t'(nib) : CH_LC_A + byte_t'(nib) - 8'd10;
  endfunction

  task automatic put(input byte_t b, input logic done = 1'b0);
    run_buf.push_back('{value: b, last: 1'b0, done: done});
  endtask

  task automatic put_replacement();
    put(REP_0);
    put(REP_1);
    put(REP_2);
  endtask

  function automatic logic continues_seq(input byte_t b);
    if (b[7:6] != 2'b10) return 1'b0;
    if (held_cnt == 2'd1) begin
      if (held[0] == LEAD_E0 && b < E0_MIN) return 1'b0;
      if (held[0] == LEAD_ED && b > ED_MAX) return 1'b0;
      if (held[0] == LEAD_F0 && b < F0_MIN) return 1'b0;
      if (held[0] == LEAD_F4 && b > F4_MAX) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic escape_fresh(input byte_t b);
    case (b)
      CC_NUL: begin
        put(CH_QUOTE, 1'b1);
        in_str = 1'b0;
      end
      CH_QUOTE: begin
        put(CH_BSLASH);
        put(CH_QUOTE);
      end
      CH_BSLASH: begin
        put(CH_BSLASH);
        put(CH_BSLASH);
      end
      CC_BS: begin
        put(CH_BSLASH);
        put(CH_B);
      end
      CC_FF: begin
        put(CH_BSLASH);
        put(CH_F);
      end
      CC_LF: begin
        put(CH_BSLASH);
        put(CH_N);
      end
      CC_CR: begin
        put(CH_BSLASH);
        put(CH_R);
      end
      CC_TAB: begin
        put(CH_BSLASH);
        put(CH_T);
      end
      default: begin
        if (b < CC_SP) begin
          put(CH_BSLASH);
          put(CH_U);
          put(CH_ZERO);
          put(CH_ZERO);
          put(hex_char(b[7:4]));
          put(hex_char(b[3:0]));
        end else if (b < AsciiEnd) begin
          put(b);
        end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
          held[0] = b;
          held_cnt = 2'd1;
          seq_len = (b <= LEAD2_MAX) ? 3'd2 : ((b <= LEAD3_MAX) ? 3'd3 : 3'd4);
        end else begin
          put_replacement();
        end
      end
    endcase
  endtask

  task automatic quote_byte(input byte_t b);
    quoted_t tail;
    run_buf.delete();
    if (!in_str) begin
      put(CH_QUOTE);
      in_str = 1'b1;
      held_cnt = 2'd0;
      seq_len = 3'd0;
    end
    if (held_cnt != 2'd0) begin
      if (continues_seq(b)) begin
        if ({1'b0, held_cnt} + 3'd1 >= seq_len) begin
          for (int i = 0; i < held_cnt; i++) put(held[i]);
          put(b);
          held_cnt = 2'd0;
          seq_len = 3'd0;
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end else begin
        for (int i = 0; i < held_cnt; i++) put_replacement();
        held_cnt = 2'd0;
        seq_len = 3'd0;
        escape_fresh(b);
      end
    end else begin
      escape_fresh(b);
    end
    if (run_buf.size() > 0) begin
      tail = run_buf.pop_back();
      tail.last = 1'b1;
      run_buf.push_back(tail);
    end
    foreach (run_buf[i]) quoted_q.push_back(run_buf[i]);
  endtask

  task automatic check_result();
    quoted_t want;
    if (quoted_q.size() == 0) begin
      report("unexpected byte", out_byte, 8'h00);
    end else begin
      want = quoted_q.pop_front();
      if (out_byte !== want.value) report("out_byte", out_byte, want.value);
      if (out_last_of_run !== want.last) report("out_last_of_run", out_last_of_run, want.last);
      if (out_string_done !== want.done) report("out_string_done", out_string_done, want.done);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_str = 1'b0;
      held_cnt = 2'd0;
      seq_len = 3'd0;
      quoted_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) quote_byte(in_byte);
    end
    pending <= quoted_q.size();
    fail_count <= mismatches;
  end

endmodule

FILE: bench/testbench.sv
module testbench;
  import jsesc_pkg::*;

  localparam int PhaseItems = 79;
  localparam int HoldCycles = 300;
  localparam int IdleLimit = 3000;
  localparam int DrainCycles = 10;
  localparam byte_t ContMin = 8'h80;
  localparam byte_t ContMax = 8'hbf;

  logic  clk;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  byte_t in_byte = '0;
  logic  out_stall = 1'b0;
  logic  in_stall;
  logic  out_valid;
  byte_t out_byte;
  logic  out_last_of_run;
  logic  out_string_done;
  int    fail_count;
  int    pending;

  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  bit    hold_req = 1'b0;
  int    items_sent = 0;
  int    idle_cycles = 0;
  byte_t frame_q[$];

  json_string_escape_utf8_check_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done)
  );

  quote_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // output back-pressure, with a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (int n = 0; n < HoldCycles; n++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task automatic send_byte(input byte_t b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic build_utf8(input int len);
    byte_t lead;
    frame_q.delete();
    case (len)
      2: lead = byte_t'($urandom_range(LEAD_MIN, LEAD2_MAX));
      3: lead = byte_t'($urandom_range(LEAD_E0, LEAD3_MAX));
      default: lead = byte_t'($urandom_range(LEAD_F0, LEAD_F4));
    endcase
    frame_q.push_back(lead);
    if (lead == LEAD_E0) frame_q.push_back(byte_t'($urandom_range(E0_MIN, ContMax)));
    else if (lead == LEAD_ED) frame_q.push_back(byte_t'($urandom_range(ContMin, ED_MAX)));
    else if (lead == LEAD_F0) frame_q.push_back(byte_t'($urandom_range(F0_MIN, ContMax)));
    else if (lead == LEAD_F4) frame_q.push_back(byte_t'($urandom_range(ContMin, F4_MAX)));
    else frame_q.push_back(byte_t'($urandom_range(ContMin, ContMax)));
    while (frame_q.size() < len) frame_q.push_back(byte_t'($urandom_range(ContMin, ContMax)));
  endtask

  task automatic send_random_group();
    int pick;
    pick = $urandom_range(0, 99);
    frame_q.delete();
    if (pick < 30) begin
      frame_q.push_back(byte_t'($urandom_range(CC_SP, 8'h7f)));
    end else if (pick < 40) begin
      frame_q.push_back(byte_t'($urandom_range(1, CC_SP - 1)));
    end else if (pick < 45) begin
      frame_q.push_back(CC_NUL);
    end else if (pick < 75) begin
      build_utf8($urandom_range(2, 4));
    end else if (pick < 88) begin
      build_utf8($urandom_range(2, 4));
      while (frame_q.size() > $urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
      frame_q.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      frame_q.push_back(byte_t'($urandom_range(0, 255)));
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  initial begin
    byte_t directed [] = '{
      CC_NUL, CH_QUOTE, CH_BSLASH, CC_BS, CC_FF, CC_LF, CC_CR, CC_TAB, 8'h1f, 8'h7f,
      8'h80, 8'hff,
      LEAD_MIN, 8'hbf,
      LEAD_E0, 8'h9f,
      LEAD_F4, 8'h8f, 8'hbf, 8'hbf,
      LEAD_ED, E0_MIN,
      LEAD_F0, CC_NUL
    };
    int tx_pct [3] = '{36, 83, 0};
    int rx_pct [3] = '{83, 36, 0};
    int phase_start;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_byte(directed[i]);
    wait_empty();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      if (p == 2) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) send_random_group();
      wait_empty();
    end

    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/jsesc_pkg.sv
rtl/jsesc_decode.sv
rtl/jsesc_emit.sv
rtl/json_string_escape_utf8_check_unit.sv
bench/quote_checker.sv
bench/testbench.sv
